/* hdl/rrip_victim_select_top_assert.svh */
// Assertion macros for the victim select block
`ifndef RRIP_VICTIM_SELECT_TOP_ASSERT_SVH
`define RRIP_VICTIM_SELECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RRIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRIP_ASSERT_IMP(lbl, ante, cons, msg)
`define RRIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/rrip_pkg.sv */
// Shared types and constants of the replacement victim select block
package rrip_pkg;

    localparam int CTR_W      = 3;
    localparam int CTR_VALS   = 1 << CTR_W;
    localparam logic [CTR_W-1:0] CTR_HIT  = 3'd7;
    localparam logic [CTR_W-1:0] CTR_FILL = 3'd1;

    localparam int SET_IN_W   = 10;
    localparam int WAY_W      = 4;
    localparam int RND_W      = 16;

    // input beat layout
    localparam int F_SET_LSB  = 0;
    localparam int F_WAY_LSB  = F_SET_LSB + SET_IN_W;
    localparam int F_HIT_BIT  = F_WAY_LSB + WAY_W;
    localparam int F_WB_BIT   = F_HIT_BIT + 1;
    localparam int F_RND_LSB  = F_WB_BIT + 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    // set index reduction is split across the accept and read cycles
    localparam int RED_SPLIT  = 5;

    // remainder unit: bits retired per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYC    = RND_W / DIV_STEPS;

    typedef enum logic [0:0] {
        MODE_VICTIM = 1'b0,
        MODE_UPDATE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

/* hdl/rrip_row_mem.sv */
// Row store of life counters: one write port, one registered read port
module rrip_row_mem
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rrip_rem_unit.sv */
// Iterative remainder unit: random value modulo zero-way count
module rrip_rem_unit
    import rrip_pkg::*;
#(
    parameter int DIV_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int CYC_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CYC_W-1:0] cnt_reg;
    logic [RND_W-1:0] dvd_reg;
    logic [RND_W-1:0] dvd_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W:0]   trial;

    // restoring steps: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial    = {rem_next, dvd_next[RND_W-1]};
            dvd_next = dvd_next << 1;
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CYC_W'(DIV_CYC - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/rrip_row_eval.sv */
// Row logic: access update, aging by row minimum, zero-way mask and k-th zero pick
module rrip_row_eval
    import rrip_pkg::*;
#(
    parameter int WAYS  = 16,
    parameter int CNT_W = 5
)
(
    input  logic [CTR_W*WAYS-1:0] row,
    input  logic [WAY_W-1:0]      upd_way,
    input  logic                  upd_hit,
    input  logic                  upd_wb,
    input  logic [WAYS-1:0]       sel_mask,
    input  logic [CNT_W-1:0]      sel_k,
    output logic [CTR_W*WAYS-1:0] upd_row,
    output logic                  upd_en,
    output logic [CTR_W*WAYS-1:0] aged_row,
    output logic                  aged,
    output logic [WAYS-1:0]       zmask,
    output logic [CNT_W-1:0]      zcnt,
    output logic [WAY_W-1:0]      pick_way,
    output logic                  pick_found
);

    logic [CTR_VALS-1:0] present;
    logic [CTR_W-1:0]    min_val;
    logic [CTR_W-1:0]    upd_val;
    logic [CNT_W-1:0]    prefix;

    // single-way write; a writeback hit leaves the row alone
    always_comb
    begin
        upd_val = upd_hit ? CTR_HIT : CTR_FILL;
        upd_en  = (int'(upd_way) < WAYS) && !(upd_hit && upd_wb);
        for (int w = 0; w < WAYS; w++)
        begin
            upd_row[w*CTR_W +: CTR_W] = (w == int'(upd_way)) ? upd_val
                                                              : row[w*CTR_W +: CTR_W];
        end
    end

    // the lowest counter value present is the row minimum; zero when any way is zero
    always_comb
    begin
        present = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            present[row[w*CTR_W +: CTR_W]] = 1'b1;
        end
        min_val = '0;
        for (int v = CTR_VALS - 1; v >= 0; v--)
        begin
            if (present[v])
            begin
                min_val = CTR_W'(v);
            end
        end
        aged = !present[0];
    end

    always_comb
    begin
        zcnt = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            aged_row[w*CTR_W +: CTR_W] = row[w*CTR_W +: CTR_W] - min_val;
            zmask[w] = (aged_row[w*CTR_W +: CTR_W] == '0);
            zcnt     = zcnt + CNT_W'(zmask[w]);
        end
    end

    // the way whose count of zero ways below it equals k is the victim
    always_comb
    begin
        pick_way   = '0;
        pick_found = 1'b0;
        prefix     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            prefix = '0;
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < w)
                begin
                    prefix = prefix + CNT_W'(sel_mask[j]);
                end
            end
            if (sel_mask[w] && (prefix == sel_k))
            begin
                pick_way   = WAY_W'(w);
                pick_found = 1'b1;
            end
        end
    end

endmodule

/* hdl/rrip_victim_select_top.sv */
// Top level of the replacement victim select engine
//
// Per-set replacement engine keeping a 3-bit life counter for every way of every
// set in one synchronous row memory (SETS rows of 3*WAYS bits). After reset the
// block runs a clearing pass over all rows, one row a cycle, and holds s_tready
// low until it ends. Items are then handled one at a time as a read, modify and
// write back of the addressed row. An access update (tuser = 1) steps from one
// accepted beat to the next through accept, row read and row write. A victim request
// (tuser = 0) steps through accept, row read, age and write back, a pass of the
// remainder unit that reduces random_value modulo the zero-way count at 4 bits a
// cycle, and a load of the result register. A finished victim waits in the
// output register, and the next beat is taken while it waits; a second victim
// holds in its last cycle until the first is taken. Set indexes at or above SETS
// wrap modulo SETS; an update of a way at or above WAYS is dropped.
`include "rrip_victim_select_top_assert.svh"

module rrip_victim_select_top
    import rrip_pkg::*;
#(
    parameter int SETS = 1024,
    parameter int WAYS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // set_index[9:0], way_index[13:10], hit[14], is_writeback[15], random_value[31:16]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // victim_way[3:0], zero above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W = CTR_W * WAYS;
    localparam int CNT_W = $clog2(WAYS + 1);

    state_t                state_reg;
    state_t                state_next;
    logic [SET_W-1:0]      clr_reg;

    mode_t                 in_mode_reg;
    logic [SET_IN_W-1:0]   in_set_reg;
    logic [WAY_W-1:0]      in_way_reg;
    logic                  in_hit_reg;
    logic                  in_wb_reg;
    logic [RND_W-1:0]      in_rnd_reg;
    logic [SET_W-1:0]      addr_reg;
    logic [WAYS-1:0]       zmask_reg;
    logic [CNT_W-1:0]      zcnt_reg;
    logic                  out_valid_reg;
    logic [WAY_W-1:0]      out_way_reg;

    logic                  in_accept;
    logic [SET_IN_W-1:0]   set_part;
    logic [SET_IN_W-1:0]   set_full;
    logic [SET_W-1:0]      rd_addr;

    logic                  mem_we;
    logic [SET_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic [ROW_W-1:0]      mem_rdata;

    logic [ROW_W-1:0]      upd_row;
    logic                  upd_en;
    logic [ROW_W-1:0]      aged_row;
    logic                  aged;
    logic [WAYS-1:0]       zmask;
    logic [CNT_W-1:0]      zcnt;
    logic [WAY_W-1:0]      pick_way;
    logic                  pick_found;

    logic                  div_start;
    logic                  div_done;
    logic [CNT_W-1:0]      div_rem;
    logic                  out_load;

    // one restoring step of set index reduction modulo SETS
    function automatic logic [SET_IN_W-1:0] red_step(input logic [SET_IN_W-1:0] x,
                                                     input int sh);
        if ((SETS << sh) < (1 << SET_IN_W))
        begin
            if (x >= SET_IN_W'(SETS << sh))
            begin
                return x - SET_IN_W'(SETS << sh);
            end
        end
        return x;
    endfunction

    always_comb
    begin
        set_part = s_tdata[F_SET_LSB +: SET_IN_W];
        for (int i = SET_IN_W - 1; i >= RED_SPLIT; i--)
        begin
            set_part = red_step(set_part, i);
        end
        set_full = in_set_reg;
        for (int i = RED_SPLIT - 1; i >= 0; i--)
        begin
            set_full = red_step(set_full, i);
        end
        rd_addr = SET_W'(set_full);
    end

    assign in_accept = s_tvalid && s_tready;

    rrip_row_mem #(
        .DEPTH (SETS),
        .AW    (SET_W),
        .DW    (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    rrip_row_eval #(
        .WAYS  (WAYS),
        .CNT_W (CNT_W)
    ) u_eval (
        .row        (mem_rdata),
        .upd_way    (in_way_reg),
        .upd_hit    (in_hit_reg),
        .upd_wb     (in_wb_reg),
        .sel_mask   (zmask_reg),
        .sel_k      (div_rem),
        .upd_row    (upd_row),
        .upd_en     (upd_en),
        .aged_row   (aged_row),
        .aged       (aged),
        .zmask      (zmask),
        .zcnt       (zcnt),
        .pick_way   (pick_way),
        .pick_found (pick_found)
    );

    rrip_rem_unit #(
        .DIV_W (CNT_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_rnd_reg),
        .divisor   (zcnt),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = (in_mode_reg == MODE_UPDATE) ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = upd_row;
        mem_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_EVAL:
            begin
                if (in_mode_reg == MODE_UPDATE)
                begin
                    mem_we    = upd_en;
                    mem_wdata = upd_row;
                end
                else
                begin
                    mem_we    = aged;
                    mem_wdata = aged_row;
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                mem_we = 1'b0;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_set_reg  <= set_part;
            in_way_reg  <= s_tdata[F_WAY_LSB +: WAY_W];
            in_hit_reg  <= s_tdata[F_HIT_BIT];
            in_wb_reg   <= s_tdata[F_WB_BIT];
            in_rnd_reg  <= s_tdata[F_RND_LSB +: RND_W];
        end
        if (state_reg == ST_READ)
        begin
            addr_reg <= rd_addr;
        end
        if (state_reg == ST_EVAL)
        begin
            zmask_reg <= zmask;
            zcnt_reg  <= zcnt;
        end
        if (out_load)
        begin
            out_way_reg <= pick_way;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_way_reg);

    `RRIP_ASSERT_IMP(a_aging_leaves_zero, state_reg == ST_EVAL && in_mode_reg == MODE_VICTIM, zcnt != '0, "aged row has no zero way")
    `RRIP_ASSERT_IMP(a_rem_below_count, state_reg == ST_EMIT, div_rem < zcnt_reg, "remainder not below zero-way count")
    `RRIP_ASSERT_IMP(a_pick_found, state_reg == ST_EMIT, pick_found, "no victim way matches the remainder")
    `RRIP_ASSERT_NEXT(a_emit_done, state_reg == ST_EMIT && out_load, m_tvalid && state_reg == ST_IDLE, "victim not presented after load")

endmodule

/* tb/tb_rrip_victim_select_top.sv */
// Testbench for the replacement victim select engine: directed and random traffic checked against a row model
module tb_rrip_victim_select_top
    import rrip_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS      = 1024;
    localparam int NWAYS      = 16;
    localparam int RAND_ITEMS = 1200;
    localparam int HOLD_CYC   = 500;
    localparam int DRAIN_CYC  = 20;

    typedef struct {
        mode_t       mode;
        logic [9:0]  set_idx;
        logic [3:0]  way;
        logic        hit;
        logic        wb;
        logic [15:0] rnd;
    } access_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // model of the counter store
    logic [CTR_W-1:0] life_ctr [NSETS][NWAYS];

    access_t     pending_beats [$];
    logic [3:0]  expected_victims [$];
    access_t     cur_beat;

    int unsigned beats_taken = 0;
    int unsigned n_victims = 0;
    int unsigned n_aged = 0;
    int unsigned n_updates = 0;
    int unsigned n_dropped = 0;
    int unsigned n_checked = 0;
    int unsigned errors = 0;

    int unsigned tx_gap = 0;
    bit          tx_burst = 1'b0;
    int unsigned rx_wait = 0;
    bit          rx_burst = 1'b0;
    logic        rx_hold = 1'b0;

    rrip_victim_select_top #(
        .SETS(NSETS),
        .WAYS(NWAYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic access_t make_beat(mode_t m, int unsigned s, int unsigned w,
                                          int unsigned h, int unsigned b, int unsigned r);
        access_t a;
        a.mode    = m;
        a.set_idx = s[9:0];
        a.way     = w[3:0];
        a.hit     = h[0];
        a.wb      = b[0];
        a.rnd     = r[15:0];
        return a;
    endfunction

    // append one beat to the send queue
    task automatic enqueue_beat(input access_t a);
        pending_beats.insert(pending_beats.size(), a);
    endtask

    // apply one accepted beat to the counter model, queue the victim it yields
    task automatic apply_beat(input access_t a);
        int unsigned s;
        int unsigned zeros;
        int unsigned k;
        logic [CTR_W-1:0] minv;
        logic [3:0] pick;
        s = a.set_idx % NSETS;
        if (a.mode == MODE_UPDATE)
        begin
            if (a.way < NWAYS && !(a.hit && a.wb))
            begin
                life_ctr[s][a.way] = a.hit ? CTR_HIT : CTR_FILL;
                n_updates++;
            end
            else
                n_dropped++;
        end
        else
        begin
            zeros = 0;
            for (int w = 0; w < NWAYS; w++)
                if (life_ctr[s][w] == 0)
                    zeros++;
            if (zeros == 0)
            begin
                // age the row by its minimum so at least one way reaches zero
                minv = '1;
                for (int w = 0; w < NWAYS; w++)
                    if (life_ctr[s][w] < minv)
                        minv = life_ctr[s][w];
                for (int w = 0; w < NWAYS; w++)
                begin
                    life_ctr[s][w] = life_ctr[s][w] - minv;
                    if (life_ctr[s][w] == 0)
                        zeros++;
                end
                n_aged++;
            end
            if (zeros == 0)
                zeros = 1;
            k = a.rnd % zeros;
            pick = '0;
            for (int w = 0; w < NWAYS; w++)
            begin
                if (life_ctr[s][w] == 0)
                begin
                    if (k == 0)
                    begin
                        pick = w[3:0];
                        break;
                    end
                    k--;
                end
            end
            expected_victims.insert(expected_victims.size(), pick);
            n_victims++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        access_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_beat(cur_beat);
                beats_taken <= beats_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    nxt = pending_beats.pop_front();
                    cur_beat = nxt;
                    s_tdata  <= {nxt.rnd, nxt.wb, nxt.hit, nxt.way, nxt.set_idx};
                    s_tuser  <= nxt.mode;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = !tx_burst;
                    tx_gap <= tx_burst ? 0 : $urandom_range(0, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned wait_cyc;
        logic [3:0] exp_way;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end
        else
        begin
            wait_cyc = rx_wait;
            if (m_tvalid && m_tready)
            begin
                if (expected_victims.size() == 0)
                begin
                    $display("%0t: unexpected victim beat, actual %0d", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    exp_way = expected_victims.pop_front();
                    n_checked++;
                    if (m_tdata !== {{(OUT_DATA_W-4){1'b0}}, exp_way})
                    begin
                        $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                                 $time, exp_way, m_tdata);
                        errors++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                wait_cyc = rx_burst ? 0 : $urandom_range(0, 7);
            end
            if (rx_hold)
            begin
                rx_wait  <= wait_cyc;
                m_tready <= 1'b0;
            end
            else if (wait_cyc != 0)
            begin
                rx_wait  <= wait_cyc - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_wait  <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    // long output stall so the block backs up and stops taking beats
    initial
    begin
        wait (beats_taken >= 400);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #5ms;
        $display("%0t: timeout, %0d results still outstanding", $time,
                 expected_victims.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int unsigned hot_sets [8];
        int unsigned total;
        int unsigned s;
        int unsigned pick;
        bit all_hits;
        int unsigned h;

        for (int i = 0; i < NSETS; i++)
            for (int w = 0; w < NWAYS; w++)
                life_ctr[i][w] = '0;

        // directed: empty rows, ignored writeback hit, writeback fill, aging
        enqueue_beat(make_beat(MODE_VICTIM, 0, 0, 0, 0, 0));
        enqueue_beat(make_beat(MODE_VICTIM, 1023, 15, 1, 1, 16'hFFFF));
        enqueue_beat(make_beat(MODE_UPDATE, 0, 15, 1, 1, 0));
        enqueue_beat(make_beat(MODE_UPDATE, 0, 0, 0, 0, 16'hFFFF));
        enqueue_beat(make_beat(MODE_VICTIM, 0, 0, 0, 0, 0));
        for (int w = 0; w < NWAYS; w++)
            if (w == 5)
                enqueue_beat(make_beat(MODE_UPDATE, 1023, w, 0, 1, 16'h5555));
            else
                enqueue_beat(make_beat(MODE_UPDATE, 1023, w, 1, 0, 16'hAAAA));
        enqueue_beat(make_beat(MODE_VICTIM, 1023, 0, 0, 0, 16'hFFFF));
        enqueue_beat(make_beat(MODE_VICTIM, 1023, 0, 0, 0, 16'h1234));
        enqueue_beat(make_beat(MODE_UPDATE, 512, 15, 1, 0, 0));

        hot_sets[0] = 0;
        hot_sets[1] = 1023;
        for (int i = 2; i < 8; i++)
            hot_sets[i] = $urandom_range(0, NSETS - 1);

        total = 0;
        while (total < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            s = hot_sets[$urandom_range(0, 7)];
            if (pick < 15)
            begin
                // fill every way of a row, then ask for victims
                all_hits = ($urandom_range(0, 3) == 0);
                for (int w = 0; w < NWAYS; w++)
                begin
                    h = (all_hits || $urandom_range(0, 3) != 0) ? 1 : 0;
                    enqueue_beat(make_beat(MODE_UPDATE, s, w, h,
                        (h != 0) ? 0 : $urandom_range(0, 1), $urandom_range(0, 65535)));
                end
                total += NWAYS;
                repeat ($urandom_range(1, 3))
                begin
                    enqueue_beat(make_beat(MODE_VICTIM, s,
                        $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 65535)));
                    total++;
                end
            end
            else if (pick < 25)
            begin
                enqueue_beat(make_beat(mode_t'($urandom_range(0, 1)),
                    $urandom_range(0, NSETS - 1), $urandom_range(0, 15),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 65535)));
                total++;
            end
            else
            begin
                enqueue_beat(make_beat(mode_t'($urandom_range(0, 1)), s,
                    $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 65535)));
                total++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_victims.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Run covered %0d beats: %0d victim requests (%0d with row aging),",
                 beats_taken, n_victims, n_aged);
        $display("%0d counter updates, %0d dropped updates, %0d victims checked.",
                 n_updates, n_dropped, n_checked);
        if (errors == 0 && expected_victims.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
